FILE: rtl/ctau_pkg.sv
package ctau_pkg;

    localparam int FRAC_BITS  = 8;
    localparam int NORM_BITS  = 16;
    localparam int CMD_W      = 2;
    localparam int COMP_W     = 24;
    localparam int RANGE_W    = 23;
    localparam int WORD_W     = 32;
    localparam int ARGB_W     = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = RANGE_W;
    localparam int LANES      = 4;
    localparam int NQ_W       = NORM_BITS + 1;
    localparam int REM_W      = RANGE_W + 1;
    localparam int DIV_STEPS  = 3;
    localparam int DIV_STAGES = (NQ_W + DIV_STEPS) / DIV_STEPS;
    localparam int DQ_W       = DIV_STAGES * DIV_STEPS;
    localparam int SH_W       = NORM_BITS - FRAC_BITS;
    localparam int UN_W       = RANGE_W + SH_W;
    localparam int KIND_W     = 3;
    localparam int SECT_W     = 3;

    localparam logic [NQ_W-1:0] ONE_N = NQ_W'(1) << NORM_BITS;

    localparam logic [CMD_W-1:0] CMD_THREE  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_GRAY   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PACKED = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_COLOR_MODEL  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_ENABLE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_X      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_Y      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_Z      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_A      = 3'd5;

    localparam logic [RANGE_W-1:0] RANGE_RESET = 23'd65280;

    localparam int LANE_X = 0;
    localparam int LANE_Y = 1;
    localparam int LANE_Z = 2;
    localparam int LANE_A = 3;

    localparam logic [KIND_W-1:0] KIND_RGB    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_HSB    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_GRAY   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_PACKED = 3'd3;
    localparam logic [KIND_W-1:0] KIND_PASS   = 3'd4;
    localparam logic [KIND_W-1:0] KIND_NONE   = 3'd5;

    typedef logic [LANES-1:0][RANGE_W-1:0] ranges_t;

    typedef struct packed {
        logic [KIND_W-1:0]              kind;
        logic [WORD_W-1:0]              word;
        logic [LANES-1:0][RANGE_W-1:0]  c;
    } side_t;

    typedef struct packed {
        logic [LANES-1:0][REM_W-1:0] rem;
        logic [LANES-1:0][DQ_W-1:0]  quo;
    } div_t;

    typedef struct packed {
        logic [KIND_W-1:0]            kind;
        logic [WORD_W-1:0]            word;
        logic [LANES-1:0][UN_W-1:0]   n;
    } mix_t;

    function automatic logic [7:0] chan(input logic [UN_W-1:0] n);
        logic [UN_W+7:0] m;
        logic [UN_W+7:0] sh;
        m  = {n, 8'd0} - {8'd0, n};
        sh = m >> NORM_BITS;
        if (|sh[UN_W+7:8])
        begin
            return 8'hff;
        end
        return sh[7:0];
    endfunction

endpackage

FILE: rtl/ctau_req_if.sv
interface ctau_req_if;
    logic                                  valid;
    logic                                  ready;
    logic [ctau_pkg::CMD_W-1:0]            cmd;
    logic signed [ctau_pkg::COMP_W-1:0]    comp_x;
    logic signed [ctau_pkg::COMP_W-1:0]    comp_y;
    logic signed [ctau_pkg::COMP_W-1:0]    comp_z;
    logic signed [ctau_pkg::COMP_W-1:0]    comp_a;
    logic [ctau_pkg::WORD_W-1:0]           packed_req;

    modport source (output valid, cmd, comp_x, comp_y, comp_z, comp_a, packed_req,
                    input ready);
    modport sink (input valid, cmd, comp_x, comp_y, comp_z, comp_a, packed_req,
                  output ready);
endinterface

FILE: rtl/ctau_res_if.sv
interface ctau_res_if;
    logic                          valid;
    logic                          ready;
    logic [ctau_pkg::ARGB_W-1:0]   argb;
    logic                          translucent;

    modport source (output valid, argb, translucent, input ready);
    modport sink (input valid, argb, translucent, output ready);
endinterface

FILE: rtl/ctau_div_stage.sv
module ctau_div_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  logic              valid_in,
    input  ctau_pkg::div_t    div_in,
    input  ctau_pkg::side_t   side_in,
    input  ctau_pkg::ranges_t rng,
    output logic              valid_out,
    output ctau_pkg::div_t    div_out,
    output ctau_pkg::side_t   side_out
);

    logic            valid_reg;
    ctau_pkg::div_t  div_reg;
    ctau_pkg::div_t  div_next;
    ctau_pkg::side_t side_reg;

    // restoring steps: compare, subtract, double
    always_comb
    begin
        logic [ctau_pkg::REM_W-1:0] r;
        logic [ctau_pkg::DQ_W-1:0]  q;
        logic                       bit_q;
        div_next = div_in;
        for (int l = 0; l < ctau_pkg::LANES; l++)
        begin
            r = div_in.rem[l];
            q = div_in.quo[l];
            for (int j = 0; j < ctau_pkg::DIV_STEPS; j++)
            begin
                bit_q = (r >= {1'b0, rng[l]});
                if (bit_q)
                begin
                    r = r - {1'b0, rng[l]};
                end
                r = {r[ctau_pkg::REM_W-2:0], 1'b0};
                q = {q[ctau_pkg::DQ_W-2:0], bit_q};
            end
            div_next.rem[l] = r;
            div_next.quo[l] = q;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            div_reg  <= div_next;
            side_reg <= side_in;
        end
    end

    assign valid_out = valid_reg;
    assign div_out   = div_reg;
    assign side_out  = side_reg;

endmodule

FILE: rtl/ctau_hsb.sv
module ctau_hsb (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            adv,
    input  logic            valid_in,
    input  ctau_pkg::mix_t  mix_in,
    output logic            valid_out,
    output ctau_pkg::mix_t  mix_out
);

    localparam int N = ctau_pkg::NORM_BITS;
    localparam int Q = ctau_pkg::NQ_W;

    logic                          s1_valid_reg;
    ctau_pkg::mix_t                s1_mix_reg;
    logic [ctau_pkg::SECT_W-1:0]   s1_sector_reg;
    logic [Q-1:0]                  s1_sf_reg;
    logic [Q-1:0]                  s1_sf1_reg;
    logic                          s2_valid_reg;
    ctau_pkg::mix_t                s2_mix_reg;

    logic [Q-1:0]       h;
    logic [Q-1:0]       s;
    logic [N+2:0]       w;
    logic [N-1:0]       f;
    logic [Q-1:0]       omf;
    logic [Q+N-1:0]     sf_prod;
    logic [2*Q-1:0]     sf1_prod;
    logic [ctau_pkg::SECT_W-1:0] sector_next;
    logic [Q-1:0]       sf_next;
    logic [Q-1:0]       sf1_next;

    // sector and fraction of the hue, and saturation times the fraction and its complement
    always_comb
    begin
        h           = mix_in.n[ctau_pkg::LANE_X][Q-1:0];
        s           = mix_in.n[ctau_pkg::LANE_Y][Q-1:0];
        w           = (N+3)'(h[N-1:0]) * (N+3)'(6);
        sector_next = w[N+2:N];
        f           = w[N-1:0];
        omf         = ctau_pkg::ONE_N - Q'(f);
        sf_prod     = s * f;
        sf1_prod    = s * omf;
        sf_next     = sf_prod[N +: Q];
        sf1_next    = sf1_prod[N +: Q];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= valid_in;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_mix_reg    <= mix_in;
            s1_sector_reg <= sector_next;
            s1_sf_reg     <= sf_next;
            s1_sf1_reg    <= sf1_next;
        end
    end

    logic [Q-1:0]   v2;
    logic [Q-1:0]   s2;
    logic [2*Q-1:0] p_prod;
    logic [2*Q-1:0] q_prod;
    logic [2*Q-1:0] t_prod;
    logic [Q-1:0]   p;
    logic [Q-1:0]   qv;
    logic [Q-1:0]   t;
    ctau_pkg::mix_t mix_next;

    always_comb
    begin
        v2     = s1_mix_reg.n[ctau_pkg::LANE_Z][Q-1:0];
        s2     = s1_mix_reg.n[ctau_pkg::LANE_Y][Q-1:0];
        p_prod = v2 * (ctau_pkg::ONE_N - s2);
        q_prod = v2 * (ctau_pkg::ONE_N - s1_sf_reg);
        t_prod = v2 * (ctau_pkg::ONE_N - s1_sf1_reg);
        p      = p_prod[N +: Q];
        qv     = q_prod[N +: Q];
        t      = t_prod[N +: Q];
        mix_next = s1_mix_reg;
        if (s1_mix_reg.kind == ctau_pkg::KIND_HSB && s2 != '0)
        begin
            case (s1_sector_reg)
                3'd0:
                begin
                    mix_next.n[0] = ctau_pkg::UN_W'(v2);
                    mix_next.n[1] = ctau_pkg::UN_W'(t);
                    mix_next.n[2] = ctau_pkg::UN_W'(p);
                end
                3'd1:
                begin
                    mix_next.n[0] = ctau_pkg::UN_W'(qv);
                    mix_next.n[1] = ctau_pkg::UN_W'(v2);
                    mix_next.n[2] = ctau_pkg::UN_W'(p);
                end
                3'd2:
                begin
                    mix_next.n[0] = ctau_pkg::UN_W'(p);
                    mix_next.n[1] = ctau_pkg::UN_W'(v2);
                    mix_next.n[2] = ctau_pkg::UN_W'(t);
                end
                3'd3:
                begin
                    mix_next.n[0] = ctau_pkg::UN_W'(p);
                    mix_next.n[1] = ctau_pkg::UN_W'(qv);
                    mix_next.n[2] = ctau_pkg::UN_W'(v2);
                end
                3'd4:
                begin
                    mix_next.n[0] = ctau_pkg::UN_W'(t);
                    mix_next.n[1] = ctau_pkg::UN_W'(p);
                    mix_next.n[2] = ctau_pkg::UN_W'(v2);
                end
                default:
                begin
                    mix_next.n[0] = ctau_pkg::UN_W'(v2);
                    mix_next.n[1] = ctau_pkg::UN_W'(p);
                    mix_next.n[2] = ctau_pkg::UN_W'(qv);
                end
            endcase
        end
        else if (s1_mix_reg.kind == ctau_pkg::KIND_HSB)
        begin
            // no saturation: gray at brightness
            mix_next.n[0] = ctau_pkg::UN_W'(v2);
            mix_next.n[1] = ctau_pkg::UN_W'(v2);
            mix_next.n[2] = ctau_pkg::UN_W'(v2);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_mix_reg <= mix_next;
        end
    end

    assign valid_out = s2_valid_reg;
    assign mix_out   = s2_mix_reg;

endmodule

FILE: rtl/ctau_pack.sv
module ctau_pack (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         adv,
    input  logic                         valid_in,
    input  ctau_pkg::mix_t               mix_in,
    output logic                         out_valid,
    output logic [ctau_pkg::ARGB_W-1:0]  argb,
    output logic                         translucent
);

    localparam int N = ctau_pkg::NORM_BITS;
    localparam int Q = ctau_pkg::NQ_W;

    logic                         valid_reg;
    logic [ctau_pkg::ARGB_W-1:0]  argb_reg;
    logic [ctau_pkg::ARGB_W-1:0]  argb_next;
    logic                         translucent_reg;
    logic [7:0]                   top;
    logic [Q+7:0]                 a_prod;
    logic [7:0]                   a;
    logic [7:0]                   r;
    logic [7:0]                   g;
    logic [7:0]                   b;

    always_comb
    begin
        top    = mix_in.word[31:24];
        a_prod = top * mix_in.n[ctau_pkg::LANE_A][Q-1:0];
        a      = ctau_pkg::chan(mix_in.n[ctau_pkg::LANE_A]);
        r      = ctau_pkg::chan(mix_in.n[0]);
        g      = ctau_pkg::chan(mix_in.n[1]);
        b      = ctau_pkg::chan(mix_in.n[2]);
        case (mix_in.kind)
            ctau_pkg::KIND_PASS:   argb_next = mix_in.word;
            ctau_pkg::KIND_PACKED: argb_next = {a_prod[N +: 8], mix_in.word[23:0]};
            ctau_pkg::KIND_NONE:   argb_next = '0;
            default:               argb_next = {a, r, g, b};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            argb_reg        <= argb_next;
            translucent_reg <= (argb_next[31:24] != 8'hff);
        end
    end

    assign out_valid   = valid_reg;
    assign argb        = argb_reg;
    assign translucent = translucent_reg;

    a_flag: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (translucent_reg == (argb_reg[31:24] != 8'hff)))
        else $error("translucent flag disagrees with alpha byte");

    a_pass: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && valid_in && mix_in.kind == ctau_pkg::KIND_PASS)
        |=> argb_reg == $past(mix_in.word))
        else $error("opaque packed word altered");

    a_none: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && valid_in && mix_in.kind == ctau_pkg::KIND_NONE)
        |=> (argb_reg == '0 && translucent_reg))
        else $error("unused command gave a colour");

endmodule

FILE: rtl/color_to_argb_converter_unit.sv
// channel  dir  handshake      payload
// req      in   valid / ready  cmd, comp_x, comp_y, comp_z, comp_a, packed_req
// res      out  valid / ready  argb, translucent
// cfg      in   cfg_we         cfg_index, cfg_data
// one request per cycle, unless a result waits untaken at the output
// a request passes the prepare stage, six divider stages of three quotient bits,
// two hue stages and the output register
// all stages hold together while a result waits untaken; nothing is lost or repeated
// reset clears valid bits and loads the register defaults; no clearing pass
module color_to_argb_converter_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    ctau_req_if.sink                           req,
    ctau_res_if.source                         res,
    input  logic                               cfg_we,
    input  logic [ctau_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ctau_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int RW = ctau_pkg::RANGE_W;

    logic            color_model_reg;
    logic            scale_enable_reg;
    logic [RW-1:0]   range_x_reg;
    logic [RW-1:0]   range_y_reg;
    logic [RW-1:0]   range_z_reg;
    logic [RW-1:0]   range_a_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_model_reg  <= 1'b0;
            scale_enable_reg <= 1'b1;
            range_x_reg      <= ctau_pkg::RANGE_RESET;
            range_y_reg      <= ctau_pkg::RANGE_RESET;
            range_z_reg      <= ctau_pkg::RANGE_RESET;
            range_a_reg      <= ctau_pkg::RANGE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ctau_pkg::CFG_COLOR_MODEL:  color_model_reg  <= cfg_data[0];
                ctau_pkg::CFG_SCALE_ENABLE: scale_enable_reg <= cfg_data[0];
                ctau_pkg::CFG_RANGE_X:      range_x_reg      <= cfg_data;
                ctau_pkg::CFG_RANGE_Y:      range_y_reg      <= cfg_data;
                ctau_pkg::CFG_RANGE_Z:      range_z_reg      <= cfg_data;
                ctau_pkg::CFG_RANGE_A:      range_a_reg      <= cfg_data;
                default: ;
            endcase
        end
    end

    ctau_pkg::ranges_t rng;
    assign rng = {range_a_reg, range_z_reg, range_y_reg, range_x_reg};

    logic adv;
    logic out_valid;
    assign adv       = !out_valid || res.ready;
    assign req.ready = adv;

    function automatic logic [RW-1:0] clampv(input logic [ctau_pkg::COMP_W-1:0] v,
                                             input logic [RW-1:0] range);
        if (v[ctau_pkg::COMP_W-1])
        begin
            return '0;
        end
        if (v[RW-1:0] > range)
        begin
            return range;
        end
        return v[RW-1:0];
    endfunction

    // prepare: clamp and classify
    logic [ctau_pkg::WORD_W+ctau_pkg::FRAC_BITS-1:0] wsh;
    logic                    small_gray;
    logic                    alpha_full;
    logic [RW-1:0]           gray_c;
    ctau_pkg::side_t         side_next;

    always_comb
    begin
        wsh        = {req.packed_req, {ctau_pkg::FRAC_BITS{1'b0}}};
        small_gray = (req.packed_req[31:24] == 8'd0) &&
                     (wsh <= (ctau_pkg::WORD_W+ctau_pkg::FRAC_BITS)'(range_x_reg));
        alpha_full = !req.comp_a[ctau_pkg::COMP_W-1] && (req.comp_a[RW-1:0] == range_a_reg);
        gray_c     = wsh[RW-1:0];
        side_next.word = req.packed_req;
        side_next.c[ctau_pkg::LANE_X] = clampv(req.comp_x, range_x_reg);
        side_next.c[ctau_pkg::LANE_Y] = clampv(req.comp_y, range_y_reg);
        side_next.c[ctau_pkg::LANE_Z] = clampv(req.comp_z, range_z_reg);
        side_next.c[ctau_pkg::LANE_A] = clampv(req.comp_a, range_a_reg);
        case (req.cmd)
            ctau_pkg::CMD_THREE:
                side_next.kind = color_model_reg ? ctau_pkg::KIND_HSB : ctau_pkg::KIND_RGB;
            ctau_pkg::CMD_GRAY:
                side_next.kind = ctau_pkg::KIND_GRAY;
            ctau_pkg::CMD_PACKED:
            begin
                if (small_gray)
                begin
                    side_next.kind = ctau_pkg::KIND_GRAY;
                    side_next.c[ctau_pkg::LANE_X] = gray_c;
                end
                else if (alpha_full)
                begin
                    side_next.kind = ctau_pkg::KIND_PASS;
                end
                else
                begin
                    side_next.kind = ctau_pkg::KIND_PACKED;
                end
            end
            default:
                side_next.kind = ctau_pkg::KIND_NONE;
        endcase
    end

    logic            prep_valid_reg;
    ctau_pkg::side_t prep_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prep_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            prep_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prep_side_reg <= side_next;
        end
    end

    ctau_pkg::div_t div_init;
    always_comb
    begin
        for (int l = 0; l < ctau_pkg::LANES; l++)
        begin
            div_init.rem[l] = {1'b0, prep_side_reg.c[l]};
            div_init.quo[l] = '0;
        end
    end

    logic            dv   [ctau_pkg::DIV_STAGES+1];
    ctau_pkg::div_t  dd   [ctau_pkg::DIV_STAGES+1];
    ctau_pkg::side_t ds   [ctau_pkg::DIV_STAGES+1];

    assign dv[0] = prep_valid_reg;
    assign dd[0] = div_init;
    assign ds[0] = prep_side_reg;

    for (genvar k = 0; k < ctau_pkg::DIV_STAGES; k++)
    begin : g_div
        ctau_div_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .valid_in  (dv[k]),
            .div_in    (dd[k]),
            .side_in   (ds[k]),
            .rng       (rng),
            .valid_out (dv[k+1]),
            .div_out   (dd[k+1]),
            .side_out  (ds[k+1])
        );
    end

    // pick divided or plain fraction per lane
    ctau_pkg::mix_t mix_in;
    always_comb
    begin
        ctau_pkg::side_t sd;
        logic [ctau_pkg::NQ_W-1:0] nq;
        logic use_div;
        sd = ds[ctau_pkg::DIV_STAGES];
        mix_in.kind = sd.kind;
        mix_in.word = sd.word;
        for (int l = 0; l < ctau_pkg::LANES; l++)
        begin
            nq = (rng[l] == '0) ? '0 :
                 dd[ctau_pkg::DIV_STAGES].quo[l][ctau_pkg::DQ_W-1 -: ctau_pkg::NQ_W];
            use_div = scale_enable_reg ||
                      (sd.kind == ctau_pkg::KIND_HSB && l != ctau_pkg::LANE_A) ||
                      (sd.kind == ctau_pkg::KIND_PACKED && l == ctau_pkg::LANE_A);
            mix_in.n[l] = use_div ? ctau_pkg::UN_W'(nq) :
                          {sd.c[l], {ctau_pkg::SH_W{1'b0}}};
        end
        if (sd.kind == ctau_pkg::KIND_GRAY)
        begin
            mix_in.n[ctau_pkg::LANE_Y] = mix_in.n[ctau_pkg::LANE_X];
            mix_in.n[ctau_pkg::LANE_Z] = mix_in.n[ctau_pkg::LANE_X];
        end
    end

    logic           hsb_valid;
    ctau_pkg::mix_t hsb_mix;

    ctau_hsb u_hsb (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .valid_in  (dv[ctau_pkg::DIV_STAGES]),
        .mix_in    (mix_in),
        .valid_out (hsb_valid),
        .mix_out   (hsb_mix)
    );

    ctau_pack u_pack (
        .clk         (clk),
        .rst_n       (rst_n),
        .adv         (adv),
        .valid_in    (hsb_valid),
        .mix_in      (hsb_mix),
        .out_valid   (out_valid),
        .argb        (res.argb),
        .translucent (res.translucent)
    );

    assign res.valid = out_valid;

endmodule

FILE: tb/color_to_argb_converter_unit_tb.sv
`timescale 1ns / 1ps
module color_to_argb_converter_unit_tb;

    typedef struct {
        logic [ctau_pkg::CMD_W-1:0]         cmd;
        logic signed [ctau_pkg::COMP_W-1:0] x;
        logic signed [ctau_pkg::COMP_W-1:0] y;
        logic signed [ctau_pkg::COMP_W-1:0] z;
        logic signed [ctau_pkg::COMP_W-1:0] a;
        logic [ctau_pkg::WORD_W-1:0]        word;
    } color_req_t;

    typedef struct {
        logic [ctau_pkg::ARGB_W-1:0] argb;
        logic                        translucent;
    } argb_res_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [ctau_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [ctau_pkg::CFG_DATA_W-1:0] cfg_data;

    ctau_req_if req_ch ();
    ctau_res_if res_ch ();

    color_to_argb_converter_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch.sink),
        .res       (res_ch.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // shadow registers
    logic                          m_model;
    logic                          m_scale;
    logic [ctau_pkg::RANGE_W-1:0]  m_rx, m_ry, m_rz, m_ra;

    color_req_t pending_reqs[$];
    argb_res_t  expected_argb[$];
    int errors;
    int send_idle_pct;
    int recv_idle_pct;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint unsigned clamp_comp(longint signed v, longint unsigned r);
        if (v < 0)
            return 0;
        if (longint'(r) < v)
            return r;
        return longint'(v);
    endfunction

    function automatic longint unsigned ratio(longint unsigned v, longint unsigned r);
        if (r == 0)
            return 0;
        return (v << ctau_pkg::NORM_BITS) / r;
    endfunction

    function automatic longint unsigned normalise(longint signed v, longint unsigned r,
                                                  logic sc);
        longint unsigned c;
        c = clamp_comp(v, r);
        if (sc)
            return ratio(c, r);
        return c << (ctau_pkg::NORM_BITS - ctau_pkg::FRAC_BITS);
    endfunction

    function automatic logic [7:0] to_byte(longint unsigned n);
        longint unsigned c;
        c = (255 * n) >> ctau_pkg::NORM_BITS;
        return (c > 255) ? 8'hff : c[7:0];
    endfunction

    function automatic argb_res_t pack_argb(logic [7:0] a, logic [7:0] r, logic [7:0] g,
                                            logic [7:0] b);
        argb_res_t o;
        o.argb = {a, r, g, b};
        o.translucent = (a != 8'hff);
        return o;
    endfunction

    function automatic argb_res_t convert_color(color_req_t q);
        longint unsigned one, h, s, v, w, sector, f, p, qq, t, r, g, b, na, gv;
        logic [7:0] ab, top;
        one = longint'(1) << ctau_pkg::NORM_BITS;
        ab = to_byte(normalise(q.a, m_ra, m_scale));
        top = q.word[31:24];
        case (q.cmd)
            ctau_pkg::CMD_THREE:
            begin
                if (!m_model)
                begin
                    r = normalise(q.x, m_rx, m_scale);
                    g = normalise(q.y, m_ry, m_scale);
                    b = normalise(q.z, m_rz, m_scale);
                end
                else
                begin
                    h = ratio(clamp_comp(q.x, m_rx), m_rx);
                    s = ratio(clamp_comp(q.y, m_ry), m_ry);
                    v = ratio(clamp_comp(q.z, m_rz), m_rz);
                    if (s == 0)
                    begin
                        r = v; g = v; b = v;
                    end
                    else
                    begin
                        w = (h & (one - 1)) * 6;
                        sector = w >> ctau_pkg::NORM_BITS;
                        f = w & (one - 1);
                        p = (v * (one - s)) >> ctau_pkg::NORM_BITS;
                        qq = (v * (one - ((s * f) >> ctau_pkg::NORM_BITS)))
                             >> ctau_pkg::NORM_BITS;
                        t = (v * (one - ((s * (one - f)) >> ctau_pkg::NORM_BITS)))
                            >> ctau_pkg::NORM_BITS;
                        case (sector)
                            0: begin r = v; g = t; b = p; end
                            1: begin r = qq; g = v; b = p; end
                            2: begin r = p; g = v; b = t; end
                            3: begin r = p; g = qq; b = v; end
                            4: begin r = t; g = p; b = v; end
                            default: begin r = v; g = p; b = qq; end
                        endcase
                    end
                end
                return pack_argb(ab, to_byte(r), to_byte(g), to_byte(b));
            end
            ctau_pkg::CMD_GRAY:
            begin
                g = normalise(q.x, m_rx, m_scale);
                return pack_argb(ab, to_byte(g), to_byte(g), to_byte(g));
            end
            ctau_pkg::CMD_PACKED:
            begin
                gv = longint'(q.word) << ctau_pkg::FRAC_BITS;
                if (top == 0 && gv <= m_rx)
                begin
                    g = normalise(longint'(gv), m_rx, m_scale);
                    return pack_argb(ab, to_byte(g), to_byte(g), to_byte(g));
                end
                if (longint'(q.a) == longint'(m_ra))
                    ab = top;
                else
                begin
                    na = ratio(clamp_comp(q.a, m_ra), m_ra);
                    ab = 8'((top * na) >> ctau_pkg::NORM_BITS);
                end
                return pack_argb(ab, q.word[23:16], q.word[15:8], q.word[7:0]);
            end
            default: return pack_argb(8'h00, 8'h00, 8'h00, 8'h00);
        endcase
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        errors++;
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
    endtask

    // request driver; also drives the result ready
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (!req_ch.valid || req_ch.ready)
            begin
                if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    color_req_t q;
                    q = pending_reqs.pop_front();
                    expected_argb.push_back(convert_color(q));
                    req_ch.valid      <= 1'b1;
                    req_ch.cmd        <= q.cmd;
                    req_ch.comp_x     <= q.x;
                    req_ch.comp_y     <= q.y;
                    req_ch.comp_z     <= q.z;
                    req_ch.comp_a     <= q.a;
                    req_ch.packed_req <= q.word;
                end
                else
                    req_ch.valid <= 1'b0;
            end
            res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            argb_res_t e;
            if (expected_argb.size() == 0)
            begin
                errors++;
                $display("unexpected result %h at %0t", res_ch.argb, $time);
            end
            else
            begin
                e = expected_argb.pop_front();
                if (res_ch.argb !== e.argb)
                    report_mismatch("argb", res_ch.argb, e.argb);
                if (res_ch.translucent !== e.translucent)
                    report_mismatch("translucent", 32'(res_ch.translucent),
                                    32'(e.translucent));
            end
        end
    end

    function automatic logic signed [ctau_pkg::COMP_W-1:0] rand_comp(
        logic [ctau_pkg::RANGE_W-1:0] r);
        case ($urandom_range(9))
            0: return ctau_pkg::COMP_W'($urandom);
            1: return -ctau_pkg::COMP_W'($urandom_range(1000));
            2: return ctau_pkg::COMP_W'(r);
            3: return ctau_pkg::COMP_W'(r) + ctau_pkg::COMP_W'($urandom_range(1, 500));
            4: return '0;
            default: return ctau_pkg::COMP_W'($urandom_range(r));
        endcase
    endfunction

    function automatic color_req_t rand_req();
        color_req_t q;
        q.cmd = ($urandom_range(19) == 0) ? ctau_pkg::CMD_W'(3) :
                ctau_pkg::CMD_W'($urandom_range(2));
        q.x = rand_comp(m_rx);
        q.y = rand_comp(m_ry);
        q.z = rand_comp(m_rz);
        q.a = ($urandom_range(3) == 0) ? ctau_pkg::COMP_W'(m_ra) : rand_comp(m_ra);
        case ($urandom_range(3))
            0: q.word = $urandom_range(m_rx >> ctau_pkg::FRAC_BITS);
            1: q.word = $urandom_range(255);
            default: q.word = $urandom;
        endcase
        return q;
    endfunction

    task automatic add_req(logic [ctau_pkg::CMD_W-1:0] c, int x, int y, int z, int a,
                           logic [31:0] w);
        color_req_t q;
        q.cmd = c;
        q.x = ctau_pkg::COMP_W'(x);
        q.y = ctau_pkg::COMP_W'(y);
        q.z = ctau_pkg::COMP_W'(z);
        q.a = ctau_pkg::COMP_W'(a);
        q.word = w;
        pending_reqs.push_back(q);
    endtask

    task automatic write_reg(logic [ctau_pkg::CFG_IDX_W-1:0] idx,
                             logic [ctau_pkg::CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            ctau_pkg::CFG_COLOR_MODEL:  m_model = val[0];
            ctau_pkg::CFG_SCALE_ENABLE: m_scale = val[0];
            ctau_pkg::CFG_RANGE_X:      m_rx = val;
            ctau_pkg::CFG_RANGE_Y:      m_ry = val;
            ctau_pkg::CFG_RANGE_Z:      m_rz = val;
            default:                    m_ra = val;
        endcase
    endtask

    task automatic drain();
        wait (pending_reqs.size() == 0 && expected_argb.size() == 0);
        repeat (15) @(posedge clk);
    endtask

    initial
    begin
        logic [ctau_pkg::RANGE_W-1:0] rmax;
        rmax = {ctau_pkg::RANGE_W{1'b1}};
        errors = 0;
        send_idle_pct = 25;
        recv_idle_pct = 72;
        m_model = 1'b0; m_scale = 1'b1;
        m_rx = ctau_pkg::RANGE_RESET; m_ry = ctau_pkg::RANGE_RESET;
        m_rz = ctau_pkg::RANGE_RESET; m_ra = ctau_pkg::RANGE_RESET;
        rst_n = 1'b0;
        cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
        req_ch.valid = 1'b0; req_ch.cmd = '0; req_ch.comp_x = '0; req_ch.comp_y = '0;
        req_ch.comp_z = '0; req_ch.comp_a = '0; req_ch.packed_req = '0;
        res_ch.ready = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset defaults with rgb, gray, packed and unused commands, then hsb, then unscaled
        add_req(ctau_pkg::CMD_THREE, 65280, 0, 32640, 65280, 0);
        add_req(ctau_pkg::CMD_THREE, -8388608, 8388607, -1, -8388608, 0);
        add_req(ctau_pkg::CMD_GRAY, 8388607, 0, 0, 0, 0);
        add_req(ctau_pkg::CMD_GRAY, 12345, 0, 0, 30000, 0);
        add_req(ctau_pkg::CMD_PACKED, 0, 0, 0, 65280, 32'h0000_00ff);
        add_req(ctau_pkg::CMD_PACKED, 0, 0, 0, 65280, 32'h0000_0100);
        add_req(ctau_pkg::CMD_PACKED, 0, 0, 0, 65280, 32'h80ff_4020);
        add_req(ctau_pkg::CMD_PACKED, 0, 0, 0, 32640, 32'hffff_ffff);
        add_req(ctau_pkg::CMD_PACKED, 0, 0, 0, -5, 32'hff12_3456);
        add_req(ctau_pkg::CMD_W'(3), 1, 2, 3, 4, 32'hdead_beef);
        drain();
        write_reg(ctau_pkg::CFG_COLOR_MODEL, ctau_pkg::CFG_DATA_W'(1));
        for (int k = 0; k < 7; k++)
            add_req(ctau_pkg::CMD_THREE, k * 10880 + 100, 40000, 60000, 65280, 0);
        add_req(ctau_pkg::CMD_THREE, 1000, 0, 50000, 65280, 0);
        add_req(ctau_pkg::CMD_THREE, 65280, 65280, 65280, 100000, 0);
        drain();
        write_reg(ctau_pkg::CFG_SCALE_ENABLE, ctau_pkg::CFG_DATA_W'(0));
        add_req(ctau_pkg::CMD_GRAY, 300, 0, 0, 8388607, 0);
        add_req(ctau_pkg::CMD_THREE, 8388607, 128, 256, 255, 0);
        drain();

        for (int ph = 0; ph < 6; ph++)
        begin
            if (ph == 2)
            begin
                send_idle_pct = 72; recv_idle_pct = 25;
            end
            if (ph == 4)
            begin
                send_idle_pct = 0; recv_idle_pct = 0;
            end
            write_reg(ctau_pkg::CFG_COLOR_MODEL, ctau_pkg::CFG_DATA_W'(ph[0]));
            write_reg(ctau_pkg::CFG_SCALE_ENABLE,
                      ctau_pkg::CFG_DATA_W'($urandom_range(3) != 0));
            case (ph)
                0:
                begin
                    write_reg(ctau_pkg::CFG_RANGE_X, ctau_pkg::CFG_DATA_W'(1));
                    write_reg(ctau_pkg::CFG_RANGE_Y, rmax);
                    write_reg(ctau_pkg::CFG_RANGE_Z, ctau_pkg::CFG_DATA_W'(1));
                    write_reg(ctau_pkg::CFG_RANGE_A, rmax);
                end
                1:
                begin
                    write_reg(ctau_pkg::CFG_RANGE_X, rmax);
                    write_reg(ctau_pkg::CFG_RANGE_Y, ctau_pkg::CFG_DATA_W'(1));
                    write_reg(ctau_pkg::CFG_RANGE_Z, rmax);
                    write_reg(ctau_pkg::CFG_RANGE_A, ctau_pkg::CFG_DATA_W'(1));
                end
                default:
                begin
                    write_reg(ctau_pkg::CFG_RANGE_X,
                              ctau_pkg::CFG_DATA_W'($urandom_range(1, rmax)));
                    write_reg(ctau_pkg::CFG_RANGE_Y,
                              ctau_pkg::CFG_DATA_W'($urandom_range(1, 70000)));
                    write_reg(ctau_pkg::CFG_RANGE_Z,
                              ctau_pkg::CFG_DATA_W'($urandom_range(1, rmax)));
                    write_reg(ctau_pkg::CFG_RANGE_A,
                              ctau_pkg::CFG_DATA_W'($urandom_range(1, 70000)));
                end
            endcase
            for (int i = 0; i < 305; i++)
                pending_reqs.push_back(rand_req());
            drain();
        end

        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Regression FAIL");
        $finish;
    end
endmodule

FILE: files.f
rtl/ctau_pkg.sv
rtl/ctau_req_if.sv
rtl/ctau_res_if.sv
rtl/ctau_div_stage.sv
rtl/ctau_hsb.sv
rtl/ctau_pack.sv
rtl/color_to_argb_converter_unit.sv
tb/color_to_argb_converter_unit_tb.sv
